[sv/tpd_pkg.sv]
`default_nettype none

package tpd_pkg;

    // element formats
    localparam logic [1:0] ELEM_FP32 = 2'd0;
    localparam logic [1:0] ELEM_BF16 = 2'd1;
    localparam logic [1:0] ELEM_HALF = 2'd2;

    // end status codes
    localparam logic [1:0] STATUS_NONE    = 2'd0;
    localparam logic [1:0] STATUS_OK      = 2'd1;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd2;
    localparam logic [1:0] STATUS_PARTIAL = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ELEM_TYPE    = 2'd0;
    localparam logic [1:0] CFG_EXPECTED_CRC = 2'd1;
    localparam logic [1:0] CFG_CHECK_CRC    = 2'd2;

    // crc-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;

    // half to single widening
    localparam logic [31:0] EXP_ALL_ONES = 32'h7f80_0000;
    localparam logic [7:0]  HALF_BIAS_ADJ = 8'd112;

    typedef logic [31:0] t_word;

endpackage

`default_nettype wire

[sv/tensor_payload_decoder_top.sv]
`default_nettype none

// tensor payload decoder: takes one payload byte per transfer, runs crc-32
// (reflected, poly 0xedb88320, init all ones, final inversion) over every
// byte and packs bytes little-endian into elements of the configured format
// (fp32 passed through, bfloat16 shifted up, ieee half widened exactly to
// fp32). a result transfer comes out when an element completes, when the
// byte flagged last arrives, or both; on the last byte end_status reports ok,
// crc mismatch (wins over a partial element) or a dropped trailing partial
// element, and the crc, element buffer and byte count go back to reset.
// sustained rate is one byte per clock while the result register is not held
// by a stall; a byte passes from the input register through the crc/convert
// logic into the result register, which loads only when it is empty or being
// drained. configuration is taken on any cycle but must
// only be written while the block is idle; o_cfg_ready is always high.

module tensor_payload_decoder_top
    import tpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,

    // byte input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,

    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_value_bits,
    output logic             o_value_present,
    output logic             o_payload_end,
    output logic [1:0]       o_end_status
);

    // configuration registers
    logic [1:0]  r_elem_type;
    logic [31:0] r_expected_crc;
    logic        r_check_crc;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_data;
    logic        r_last;

    // payload state
    logic [31:0] r_crc,     n_crc;
    logic [23:0] r_partial, n_partial;
    logic [1:0]  r_pos,     n_pos;

    // result register
    logic        r_out_valid;
    logic [31:0] r_value;
    logic        r_present;
    logic        r_end;
    logic [1:0]  r_status;

    logic        advance;
    logic [31:0] crc_next;
    logic [31:0] word;
    logic        complete;
    t_word       conv_value;
    logic [1:0]  status;

    assign o_cfg_ready = 1'b1;

    // result register frees up when empty or being drained this cycle
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_type    <= ELEM_FP32;
            r_expected_crc <= 32'd0;
            r_check_crc    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ELEM_TYPE:    r_elem_type    <= i_cfg_data[1:0];
                CFG_EXPECTED_CRC: r_expected_crc <= i_cfg_data;
                CFG_CHECK_CRC:    r_check_crc    <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_data <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    tpd_crc8 u_crc (
        .i_crc  (r_crc),
        .i_byte (r_data),
        .o_crc  (crc_next)
    );

    // new byte lands at its little-endian slot
    assign word = {8'd0, r_partial} | ({24'd0, r_data} << {r_pos, 3'b000});

    // fp32 needs four bytes, the 16-bit formats two
    assign complete = (r_elem_type == ELEM_FP32) ? (r_pos == 2'd3) : (r_pos != 2'd0);

    tpd_convert u_conv (
        .i_elem_type (r_elem_type),
        .i_word      (word),
        .o_value     (conv_value)
    );

    always_comb begin
        if (!r_last) begin
            status = STATUS_NONE;
        end else if (r_check_crc && (~crc_next != r_expected_crc)) begin
            status = STATUS_CRC_ERR;
        end else if (!complete) begin
            status = STATUS_PARTIAL;
        end else begin
            status = STATUS_OK;
        end
    end

    // next payload state, back to reset after the last byte
    always_comb begin
        n_crc     = r_crc;
        n_partial = r_partial;
        n_pos     = r_pos;
        if (r_in_valid && advance) begin
            if (r_last) begin
                n_crc     = CRC_INIT;
                n_partial = 24'd0;
                n_pos     = 2'd0;
            end else begin
                n_crc = crc_next;
                if (complete) begin
                    n_partial = 24'd0;
                    n_pos     = 2'd0;
                end else begin
                    n_partial = word[23:0];
                    n_pos     = r_pos + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= CRC_INIT;
            r_partial <= 24'd0;
            r_pos     <= 2'd0;
        end else begin
            r_crc     <= n_crc;
            r_partial <= n_partial;
            r_pos     <= n_pos;
        end
    end

    // result register, only bytes that finish an element or end the payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && (complete || r_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_value   <= complete ? conv_value : 32'd0;
            r_present <= complete;
            r_end     <= r_last;
            r_status  <= status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_value_bits    = r_value;
    assign o_value_present = r_present;
    assign o_payload_end   = r_end;
    assign o_end_status    = r_status;

endmodule

`default_nettype wire

[sv/tpd_crc8.sv]
`default_nettype none

module tpd_crc8
    import tpd_pkg::*;
(
    input  wire logic [31:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [31:0] o_crc
);

    // eight bit steps of the reflected shift register, unrolled
    always_comb begin
        logic [31:0] c;
        c = i_crc ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

[sv/tpd_convert.sv]
`default_nettype none

module tpd_convert
    import tpd_pkg::*;
(
    input  wire logic [1:0]  i_elem_type,
    input  wire logic [31:0] i_word,
    output t_word            o_value
);

    logic        s;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  msb;
    logic [3:0]  shift;
    logic [9:0]  m_norm;
    logic [7:0]  ex_sub;
    t_word       half_value;

    assign s = i_word[15];
    assign e = i_word[14:10];
    assign m = i_word[9:0];

    // position of the leading one of a subnormal mantissa
    always_comb begin
        msb = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                msb = 4'(i);
            end
        end
    end

    assign shift  = 4'd10 - msb;
    assign m_norm = 10'(m << shift);
    assign ex_sub = 8'd113 - {4'd0, shift};

    always_comb begin
        if (e == 5'd0) begin
            if (m == 10'd0) begin
                half_value = {s, 31'd0};
            end else begin
                half_value = {s, ex_sub, m_norm, 13'd0};
            end
        end else if (e == 5'h1f) begin
            half_value = {s, 31'd0} | EXP_ALL_ONES | {9'd0, m, 13'd0};
        end else begin
            half_value = {s, 8'({3'd0, e} + HALF_BIAS_ADJ), m, 13'd0};
        end
    end

    always_comb begin
        case (i_elem_type)
            ELEM_FP32: o_value = i_word;
            ELEM_BF16: o_value = {i_word[15:0], 16'd0};
            default:   o_value = half_value;
        endcase
    end

endmodule

`default_nettype wire

[sv/tpd_checker.sv]
`default_nettype none

module tpd_checker
    import tpd_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_value_bits,
    input wire logic        o_value_present,
    input wire logic        o_payload_end,
    input wire logic [1:0]  o_end_status
);

    // no empty result transfer
    a_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_value_present || o_payload_end))
        else $error("result with neither element nor end");

    // value is zero without an element
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_value_present) |-> (o_value_bits == 32'd0))
        else $error("value bits set without element");

    // status only on the end of a payload
    a_status_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_payload_end == (o_end_status != STATUS_NONE)))
        else $error("end status disagrees with payload end");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_value_bits)
            && $stable(o_value_present) && $stable(o_payload_end)
            && $stable(o_end_status)))
        else $error("stalled result changed");

endmodule

bind tensor_payload_decoder_top tpd_checker u_tpd_checker (.*);

`default_nettype wire

[bench/payload_decode_checker.sv]
`timescale 1ns / 100ps

module payload_decode_checker
    import tpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,

    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,

    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_value_bits,
    input  logic        i_value_present,
    input  logic        i_payload_end,
    input  logic [1:0]  i_end_status,

    output int          o_fail_count,
    output int          o_results_pending,
    output logic [31:0] o_payload_crc
);

    typedef struct packed {
        logic [31:0] value_bits;
        logic        value_present;
        logic        payload_end;
        logic [1:0]  end_status;
    } t_decoded;

    t_decoded decoded_q[$];

    // shadow registers and decoder state
    logic [1:0]  elem_type;
    logic [31:0] crc_expected;
    logic        crc_check_en;
    logic [31:0] crc_acc;
    logic [23:0] held_bytes;
    logic [1:0]  held_count;

    function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic        sign;
        logic [4:0]  exp5;
        logic [9:0]  frac;
        logic [10:0] mant;
        logic [7:0]  exp8;
        sign = h[15];
        exp5 = h[14:10];
        frac = h[9:0];
        if (exp5 == 5'd0) begin
            if (frac == 10'd0) begin
                return {sign, 31'h0};
            end
            // subnormal: shift until the hidden bit shows up
            mant = {1'b0, frac};
            exp8 = HALF_BIAS_ADJ + 8'd1;
            for (int i = 0; i < 10; i++) begin
                if (!mant[10]) begin
                    mant = mant << 1;
                    exp8 = exp8 - 8'd1;
                end
            end
            return {sign, exp8, mant[9:0], 13'h0};
        end
        if (exp5 == 5'h1f) begin
            return {sign, 31'h0} | EXP_ALL_ONES | {9'h0, frac, 13'h0};
        end
        return {sign, {3'h0, exp5} + HALF_BIAS_ADJ, frac, 13'h0};
    endfunction

    always @(posedge i_clk) begin : monitor
        logic [31:0] word;
        int          pos;
        int          size;
        int          errs;
        t_decoded    res;
        t_decoded    want;
        errs = 0;
        if (!i_rst_n) begin
            elem_type    = ELEM_FP32;
            crc_expected = '0;
            crc_check_en = 1'b0;
            crc_acc      = CRC_INIT;
            held_bytes   = '0;
            held_count   = '0;
            decoded_q.delete();
            o_fail_count      <= 0;
            o_results_pending <= 0;
            o_payload_crc     <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ELEM_TYPE:    elem_type    = i_cfg_data[1:0];
                    CFG_EXPECTED_CRC: crc_expected = i_cfg_data;
                    CFG_CHECK_CRC:    crc_check_en = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                pos  = int'(held_count);
                size = (elem_type == ELEM_FP32) ? 4 : 2;
                word = {8'h00, held_bytes} | ({24'h0, i_data_byte} << (8 * pos));
                crc_acc = crc32_step(crc_acc, i_data_byte);
                res = '0;
                if (pos + 1 >= size) begin
                    res.value_present = 1'b1;
                    case (elem_type)
                        ELEM_FP32: res.value_bits = word;
                        ELEM_BF16: res.value_bits = {word[15:0], 16'h0};
                        default:   res.value_bits = widen_half(word[15:0]);
                    endcase
                    held_bytes = '0;
                    held_count = '0;
                end else begin
                    held_bytes = word[23:0];
                    held_count = held_count + 2'd1;
                end
                if (i_last_byte) begin
                    res.payload_end = 1'b1;
                    if (crc_check_en && ((~crc_acc) != crc_expected)) begin
                        res.end_status = STATUS_CRC_ERR;
                    end else if (held_count != 2'd0) begin
                        res.end_status = STATUS_PARTIAL;
                    end else begin
                        res.end_status = STATUS_OK;
                    end
                    o_payload_crc <= ~crc_acc;
                    crc_acc    = CRC_INIT;
                    held_bytes = '0;
                    held_count = '0;
                end
                if (res.value_present || res.payload_end) begin
                    decoded_q.push_back(res);
                end
            end

            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: value_bits=%h present=%b end=%b status=%0d",
                           i_value_bits, i_value_present, i_payload_end, i_end_status);
                    errs++;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_value_bits !== want.value_bits) begin
                        $error("value_bits: expected %h, got %h", want.value_bits, i_value_bits);
                        errs++;
                    end
                    if (i_value_present !== want.value_present) begin
                        $error("value_present: expected %b, got %b",
                               want.value_present, i_value_present);
                        errs++;
                    end
                    if (i_payload_end !== want.payload_end) begin
                        $error("payload_end: expected %b, got %b",
                               want.payload_end, i_payload_end);
                        errs++;
                    end
                    if (i_end_status !== want.end_status) begin
                        $error("end_status: expected %0d, got %0d",
                               want.end_status, i_end_status);
                        errs++;
                    end
                end
            end

            o_fail_count      <= o_fail_count + errs;
            o_results_pending <= decoded_q.size();
        end
    end

endmodule

[bench/tensor_payload_decoder_top_tb.sv]
`timescale 1ns / 100ps

module tensor_payload_decoder_top_tb;
    import tpd_pkg::*;

    // a byte passes the input register before the result register loads; pad a little
    localparam int LATENCY_CYCLES = 4;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int RANDOM_BYTES   = 1850;

    // type code 3 is unused and should decode like half
    localparam logic [1:0] ELEM_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = CFG_ELEM_TYPE;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_stall = 1'b0;

    wire logic        cfg_ready;
    wire logic        in_stall;
    wire logic        out_valid;
    wire logic [31:0] value_bits;
    wire logic        value_present;
    wire logic        payload_end;
    wire logic [1:0]  end_status;

    int          fail_count;
    int          results_pending;
    logic [31:0] payload_crc;

    int          cycle_count = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_hold  = 0;

    // sender burst shaping
    int          burst_left = 0;
    bit          quiet      = 1'b0;
    int          bytes_sent = 0;

    logic [7:0]  payload_q[$];

    always #4 clk = ~clk;

    tensor_payload_decoder_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_data_byte     (data_byte),
        .i_last_byte     (last_byte),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_value_bits    (value_bits),
        .o_value_present (value_present),
        .o_payload_end   (payload_end),
        .o_end_status    (end_status)
    );

    payload_decode_checker decode_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_data_byte       (data_byte),
        .i_last_byte       (last_byte),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_value_bits      (value_bits),
        .i_value_present   (value_present),
        .i_payload_end     (payload_end),
        .i_end_status      (end_status),
        .o_fail_count      (fail_count),
        .o_results_pending (results_pending),
        .o_payload_crc     (payload_crc)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver backpressure, switching between a few patterns so that
    // stalls land on every phase, with stall-free stretches in between
    always @(negedge clk) begin
        if (stall_hold == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_hold <= $urandom_range(16, 160);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
            default:     out_stall <= ((cycle_count % 4) != 0);
        endcase
    end

    // one register write; called at a falling edge, returns at one
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // one byte transfer; valid stays up between bytes of a burst
    task automatic put_byte(input logic [7:0] b, input logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = quiet ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid  = 1'b1;
        data_byte = b;
        last_byte = lst;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_payload(input bit with_last);
        for (int i = 0; i < payload_q.size(); i++) begin
            put_byte(payload_q[i], with_last && (i == payload_q.size() - 1));
        end
    endtask

    // mostly whole elements, now and then a ragged tail
    task automatic random_payload(input int elem_bytes);
        int n;
        n = elem_bytes * (($urandom_range(0, 15) == 0) ? $urandom_range(7, 16)
                                                        : $urandom_range(1, 6));
        if (elem_bytes > 1 && $urandom_range(0, 5) == 0) begin
            n += $urandom_range(1, elem_bytes - 1);
        end
        payload_q.delete();
        repeat (n) payload_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // drain: nothing outstanding, then let the pipeline empty out
    task automatic settle();
        in_valid = 1'b0;
        do @(posedge clk); while (results_pending != 0);
        repeat (LATENCY_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    initial begin : stimulus
        logic [1:0]  elem;
        bit          check;
        int          elem_bytes;
        logic [31:0] crc_word;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(CFG_ELEM_TYPE, {30'h0, ELEM_FP32});
        write_reg(CFG_CHECK_CRC, 32'h0);
        write_reg(CFG_EXPECTED_CRC, 32'h0);

        // fp32 pass-through with both byte extremes
        payload_q = '{8'h00, 8'hff, 8'h00, 8'hff};
        send_payload(1'b1);
        settle();

        // bfloat16 all ones
        write_reg(CFG_ELEM_TYPE, {30'h0, ELEM_BF16});
        payload_q = '{8'hff, 8'hff};
        send_payload(1'b1);
        settle();

        // half: negative zero, smallest and largest subnormal, +inf, nan
        write_reg(CFG_ELEM_TYPE, {30'h0, ELEM_HALF});
        payload_q = '{8'h00, 8'h80, 8'h01, 8'h00, 8'hff, 8'h03,
                      8'h00, 8'h7c, 8'h01, 8'hfe};
        send_payload(1'b1);
        settle();

        // unused type code behaves like half; odd trailing byte is dropped
        write_reg(CFG_ELEM_TYPE, {30'h0, ELEM_UNUSED});
        payload_q = '{8'h00, 8'h3c, 8'h55};
        send_payload(1'b1);
        settle();

        // crc mismatch takes priority over the partial element
        write_reg(CFG_CHECK_CRC, 32'h1);
        write_reg(CFG_EXPECTED_CRC, 32'hffff_ffff);
        payload_q = '{8'h5a};
        send_payload(1'b1);
        settle();

        // element begun as fp32 and finished after a switch to bfloat16
        write_reg(CFG_ELEM_TYPE, {30'h0, ELEM_FP32});
        payload_q = '{8'h12, 8'h34, 8'h56};
        send_payload(1'b0);
        settle();
        write_reg(CFG_ELEM_TYPE, {30'h0, ELEM_BF16});
        payload_q = '{8'h78};
        send_payload(1'b1);

        // random phases, each with a fresh setting
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            settle();
            quiet = ($urandom_range(0, 3) == 0);
            elem  = 2'($urandom_range(0, 3));
            check = 1'($urandom_range(0, 1));
            write_reg(CFG_ELEM_TYPE, {30'h0, elem});
            write_reg(CFG_CHECK_CRC, {31'h0, check});
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_EXPECTED_CRC, $urandom);
            end
            elem_bytes = (elem == ELEM_FP32) ? 4 : 2;
            repeat ($urandom_range(1, 4)) begin
                random_payload(elem_bytes);
                if (check) begin
                    // first pass yields the crc, second pass is checked
                    // against it, sometimes with one bit flipped
                    send_payload(1'b1);
                    settle();
                    crc_word = payload_crc;
                    if ($urandom_range(0, 3) == 0) begin
                        crc_word ^= 32'h1 << $urandom_range(0, 31);
                    end
                    write_reg(CFG_EXPECTED_CRC, crc_word);
                    send_payload(1'b1);
                end else begin
                    // an unterminated payload leaves a partial element behind
                    send_payload($urandom_range(0, 9) != 0);
                end
            end
        end

        settle();
        if (fail_count == 0 && results_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
